// File: hdl/tdpt_pkg.sv
// Shared constants and controller/datapath interface types for the prime test.
package tdpt_pkg;

    // Default width of the tested value.
    localparam int DATA_WIDTH = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // Capture a new value and reset the divisor to three.
        logic start_div;  // Begin a remainder computation for the current divisor.
        logic step_div;   // Retire one quotient bit of the remainder computation.
        logic advance;    // Move to the next odd divisor and its square.
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial;        // Value decided without any division.
        logic trivial_prime;  // Answer for a value decided without division.
        logic sq_gt_n;        // Divisor squared now exceeds the value.
        logic div_last;       // The current remainder step is the final one.
        logic rem_zero;       // The finished remainder is zero.
    } t_dp_stat;

endpackage

// File: hdl/tdpt_datapath.sv
// Datapath of the prime test: value, odd divisor, its square and a bit-serial remainder unit.
module tdpt_datapath
    import tdpt_pkg::*;
#(
    parameter int DATA_WIDTH = tdpt_pkg::DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  t_dp_cmd                      i_cmd,
    output t_dp_stat                     o_stat
);

    // A candidate is positive, so it has one bit fewer than the input word.
    localparam int NW = DATA_WIDTH - 1;
    localparam int CW = $clog2(NW);
    localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

    logic [NW-1:0] r_n;
    logic [NW-1:0] r_div;
    logic [NW+1:0] r_sq;
    logic [NW:0]   r_rem;
    logic [NW-1:0] r_shift;
    logic [CW-1:0] r_cnt;
    logic          r_trivial;
    logic          r_trivial_prime;

    logic [NW-1:0] mag;
    logic          is_neg;
    logic          is_two;
    logic          is_le_one;
    logic [NW:0]   rem_shift;
    logic [NW:0]   rem_sub;
    logic          rem_ge;
    logic [NW:0]   n_rem;

    // Classify the incoming value: sign, zero or one, two, and even values.
    assign is_neg    = i_value[DATA_WIDTH-1];
    assign mag       = i_value[NW-1:0];
    assign is_le_one = (mag <= NW'(1));
    assign is_two    = (mag == NW'(2));

    // One restoring step: shift in the next dividend bit and subtract when it fits.
    assign rem_shift = {r_rem[NW-1:0], r_shift[NW-1]};
    assign rem_sub   = rem_shift - {1'b0, r_div};
    assign rem_ge    = (rem_shift >= {1'b0, r_div});
    assign n_rem     = rem_ge ? rem_sub : rem_shift;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n             <= mag;
            r_div           <= NW'(3);
            r_sq            <= (NW+2)'(9);
            r_trivial       <= is_neg | is_le_one | ~mag[0];
            r_trivial_prime <= ~is_neg & is_two;
        end
        if (i_cmd.start_div) begin
            r_rem   <= '0;
            r_shift <= r_n;
            r_cnt   <= '0;
        end else if (i_cmd.step_div) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[NW-2:0], 1'b0};
            r_cnt   <= r_cnt + CW'(1);
        end
        // (d + 2)^2 = d^2 + 4d + 4, so the square follows the divisor without a multiplier.
        if (i_cmd.advance) begin
            r_div <= r_div + NW'(2);
            r_sq  <= r_sq + {r_div, 2'b00} + (NW+2)'(4);
        end
    end

    assign o_stat.trivial       = r_trivial;
    assign o_stat.trivial_prime = r_trivial_prime;
    assign o_stat.sq_gt_n       = (r_sq > {2'b00, r_n});
    assign o_stat.div_last      = (r_cnt == LAST_STEP);
    assign o_stat.rem_zero      = (r_rem == '0);

endmodule

// File: hdl/tdpt_ctrl.sv
// Controller of the prime test: sequences the divisor loop and holds the result beat.
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output logic     o_is_prime,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_DIV   = 5'b00100,
        S_EVAL  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_result;
    logic   n_result;
    logic   r_out_valid;
    logic   r_out_prime;
    logic   out_free;

    // The output register frees when empty or when its beat is taken.
    assign out_free = ~r_out_valid | i_out_ready;

    // Next-state and command logic.
    always_comb begin
        n_state         = r_state;
        n_result        = r_result;
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.trivial) begin
                    n_result = i_stat.trivial_prime;
                    n_state  = S_DONE;
                end else if (i_stat.sq_gt_n) begin
                    n_result = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step_div = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.rem_zero) begin
                    n_result = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, result and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_result <= n_result;
        if (r_state == S_DONE && out_free) begin
            r_out_prime <= r_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_out_prime;

    // An accepted beat always starts a check on the next cycle.
    a_load_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && i_in_valid |=> r_state == S_CHECK)
        else $error("accepted beat did not start a check");

    // The final remainder step always hands over to evaluation.
    a_div_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && i_stat.div_last |=> r_state == S_EVAL)
        else $error("remainder loop did not end after its last step");

    // A value settled without division carries its classified answer.
    a_trivial_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK && i_stat.trivial
        |=> r_state == S_DONE && r_result == $past(i_stat.trivial_prime))
        else $error("trivial value gave the wrong answer");

    // A zero remainder always reports a composite value.
    a_factor_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVAL && i_stat.rem_zero |=> r_state == S_DONE && !r_result)
        else $error("found factor did not give a composite result");

endmodule

// File: hdl/trial_division_prime_test.sv
// Top level of the trial-division prime test.
// Tests one signed value per beat and returns one is_prime beat for it. Negative values,
// zero, one and even values, two included, are answered without division. An odd value
// n of three or more is divided by 3, 5, 7, ... while the divisor squared does not
// exceed n; each divisor takes one bound check, DATA_WIDTH - 1 steps of the bit-serial
// remainder unit and one evaluation. One value is in work at a time; a new value is taken
// while the previous result still waits in the output register.
module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int DATA_WIDTH = tdpt_pkg::DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_is_prime
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencing and result handshake.
    tdpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_is_prime  (o_is_prime),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Value, divisor and remainder arithmetic.
    tdpt_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_value (i_value),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

// File: test/trial_division_prime_test_tb.sv
// Self-checking testbench for the trial-division prime test, with a scoreboard.
module trial_division_prime_test_tb;
    import tdpt_pkg::*;

    typedef logic signed [DATA_WIDTH-1:0] t_value;

    // One expected answer, kept with the value that produced it for reporting.
    typedef struct {
        t_value value;
        logic   is_prime;
    } t_verdict;

    localparam int unsigned RANDOM_VALUES = 80;
    localparam int unsigned DRAIN_CYCLES  = 60;
    // The largest positive prime alone needs the longest search; the rest are cheap.
    localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   in_valid = 1'b0;
    t_value in_value = '0;
    logic   out_ready = 1'b0;
    logic   o_in_ready;
    logic   o_out_valid;
    logic   o_is_prime;

    t_value   values_to_send[$];
    t_verdict expected_verdicts[$];

    int unsigned     in_gap = 0;
    int unsigned     out_stall = 0;
    logic            steady = 1'b0;
    int unsigned     fail_count = 0;
    int unsigned     values_sent = 0;
    int unsigned     primes_sent = 0;
    int unsigned     negatives_sent = 0;
    int unsigned     verdicts_seen = 0;
    longint unsigned cycle_count = 0;

    trial_division_prime_test #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(o_in_ready),
        .i_value(in_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_is_prime(o_is_prime)
    );

    // Answer for one value: odd divisors are tried while divisor squared stays within n.
    function automatic logic prime_by_trial_division(t_value value);
        longint unsigned n;
        longint unsigned divisor;
        if (value < 0) return 1'b0;
        n = 0;
        n[DATA_WIDTH-1:0] = value;
        if (n <= 1) return 1'b0;
        if (n == 2) return 1'b1;
        if (n[0] == 1'b0) return 1'b0;
        for (divisor = 3; divisor <= n / divisor; divisor += 2) begin
            if (n % divisor == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Idle cycles after an input beat: mostly none, some short, a few long.
    function automatic int unsigned input_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stall started on any cycle of the result side, usually none.
    function automatic int unsigned output_stall();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 85) return 0;
        if (roll < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random value, weighted so that the slow odd cases stay small.
    function automatic t_value random_value();
        int unsigned     roll;
        int unsigned     factor;
        longint unsigned top;
        longint unsigned cofactor;
        t_value          value;
        roll = $urandom_range(0, 99);
        top = (64'd1 << (DATA_WIDTH - 1)) - 1;
        value = t_value'({$urandom(), $urandom()});
        if (roll < 40) begin
            value = t_value'($urandom_range(0, 4095));
        end else if (roll < 55) begin
            value = t_value'($urandom_range(4096, 1 << 18));
        end else if (roll < 70) begin
            value[DATA_WIDTH-1] = 1'b1;
        end else if (roll < 85) begin
            // Even values over the whole range, either sign.
            value[0] = 1'b0;
        end else begin
            // Large odd composite with a small factor, so the search ends early.
            case ($urandom_range(0, 4))
                0: factor = 3;
                1: factor = 5;
                2: factor = 7;
                3: factor = 11;
                default: factor = 13;
            endcase
            cofactor = ({$urandom(), $urandom()} % (top / factor)) | 64'd1;
            value = t_value'(cofactor * factor);
        end
        return value;
    endfunction

    // Clock and the single reset at the start.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Switches now and then into stretches where neither side idles.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 499) == 0) begin
            steady <= ~steady;
        end
    end

    // Input driver: holds a beat until accepted, then idles or presents the next value.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else if (!(in_valid && !o_in_ready)) begin
            if (in_valid) begin
                expected_verdicts.push_back('{in_value, prime_by_trial_division(in_value)});
                values_sent++;
                if (prime_by_trial_division(in_value)) primes_sent++;
                if (in_value < 0) negatives_sent++;
            end
            if (in_gap != 0) begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (values_to_send.size() != 0) begin
                in_valid <= 1'b1;
                in_value <= values_to_send.pop_front();
                in_gap <= input_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each beat against the oldest expectation and drives stalls.
    always @(posedge i_clk) begin
        t_verdict oldest;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                verdicts_seen++;
                if (expected_verdicts.size() == 0) begin
                    $error("is_prime beat with no value pending: actual %0b", o_is_prime);
                    fail_count++;
                end else begin
                    oldest = expected_verdicts.pop_front();
                    if (o_is_prime !== oldest.is_prime) begin
                        $error("is_prime mismatch for value %0d: expected %0b, actual %0b",
                               oldest.value, oldest.is_prime, o_is_prime);
                        fail_count++;
                    end
                end
            end
            if (out_stall != 0) begin
                out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end else begin
                out_stall <= output_stall();
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("Timed out after %0d cycles with %0d results outstanding",
                   cycle_count, expected_verdicts.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus: directed corner values first, then weighted random values.
    initial begin
        t_value top_value;
        t_value bottom_value;
        top_value = '1;
        top_value[DATA_WIDTH-1] = 1'b0;
        bottom_value = '0;
        bottom_value[DATA_WIDTH-1] = 1'b1;

        // Sign extremes, the small trivial cases and the first odd primes.
        values_to_send.push_back(bottom_value);
        values_to_send.push_back(t_value'(-1));
        values_to_send.push_back(t_value'(-2));
        values_to_send.push_back(t_value'(0));
        values_to_send.push_back(t_value'(1));
        values_to_send.push_back(t_value'(2));
        values_to_send.push_back(t_value'(3));
        values_to_send.push_back(t_value'(4));
        values_to_send.push_back(t_value'(5));
        values_to_send.push_back(t_value'(7));
        // Prime squares, where the factor is the last divisor tried, and 15, 97, 65537.
        values_to_send.push_back(t_value'(9));
        values_to_send.push_back(t_value'(15));
        values_to_send.push_back(t_value'(25));
        values_to_send.push_back(t_value'(49));
        values_to_send.push_back(t_value'(121));
        values_to_send.push_back(t_value'(97));
        values_to_send.push_back(t_value'(63001));
        values_to_send.push_back(t_value'(65537));
        // Large values up to the top of the positive range.
        values_to_send.push_back(t_value'(64'd1 << (DATA_WIDTH - 2)));
        values_to_send.push_back(top_value - 1);
        values_to_send.push_back(top_value - 2);
        values_to_send.push_back(top_value);

        for (int unsigned k = 0; k < RANDOM_VALUES; k++) begin
            values_to_send.push_back(random_value());
        end

        @(posedge i_rst_n);
        @(negedge i_clk);
        while (values_to_send.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d values (%0d prime, %0d negative) and checked %0d results",
                 values_sent, primes_sent, negatives_sent, verdicts_seen);
        $display("under random gaps and stalls in %0d cycles.", cycle_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
